### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the gradient block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (conseq)) \
        else $error(msg);

`endif

### rtl/fdg_pkg.sv
// ----------------------------------------------------------------------------
// fdg_pkg
// Types and constants shared by the finite-difference gradient modules.
// ----------------------------------------------------------------------------
package fdg_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 16;
    localparam int FRAME_COLS_BITS = 11;
    localparam int FRAME_ROWS_BITS = 16;
    localparam int AXIS_BITS       = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_COLS  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_ROWS  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_SELECT = 2'd2;

    // axis select codes; the spare code acts as both
    localparam logic [AXIS_BITS-1:0] AXIS_VERTICAL   = 2'd0;
    localparam logic [AXIS_BITS-1:0] AXIS_HORIZONTAL = 2'd1;
    localparam logic [AXIS_BITS-1:0] AXIS_BOTH       = 2'd2;

    // reset values
    localparam int COLS_RESET = 1024;
    localparam logic [FRAME_ROWS_BITS-1:0] LAST_ROW_RESET = 16'd0;

    localparam int ROW_BITS = 16;

    // results
    localparam int OUT_BITS = 18;
    localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    // decoupling queue, power of two
    localparam int QUEUE_DEPTH = 2;

    // how one gradient component is formed from its two operands
    typedef enum logic [1:0] {
        DIFF_ZERO,       // axis unselected or of length one
        DIFF_CENTRAL,    // hi - lo (already half-scaled by the fraction bit)
        DIFF_ONE_SIDED   // 2 * (hi - lo)
    } diff_mode_t;

    typedef struct packed {
        diff_mode_t v_mode;
        diff_mode_t h_mode;
        logic       frame_end;
    } fdg_ctrl_t;

endpackage

### rtl/fdg_front.sv
// ----------------------------------------------------------------------------
// fdg_front
// Takes samples, keeps the frame position and the two line buffers, and picks
// the operands and difference kind for each result.
// ----------------------------------------------------------------------------
module fdg_front #(
    parameter int MAX_COLS    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [fdg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [fdg_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  sample_valid,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    output logic                                  sample_stall,
    input  logic                                  q_full,
    output logic                                  q_push,
    output fdg_pkg::fdg_ctrl_t                    q_ctrl,
    output logic signed [SAMPLE_BITS-1:0]         v_hi,
    output logic signed [SAMPLE_BITS-1:0]         v_lo,
    output logic signed [SAMPLE_BITS-1:0]         h_hi,
    output logic signed [SAMPLE_BITS-1:0]         h_lo
);

    localparam int IW   = $clog2(MAX_COLS);
    localparam int NCW  = $clog2(MAX_COLS + 1);
    localparam int CMPW = (NCW > fdg_pkg::FRAME_COLS_BITS) ? NCW : fdg_pkg::FRAME_COLS_BITS;
    localparam int RESET_COLS = (fdg_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS
                                                                 : fdg_pkg::COLS_RESET;

    // configuration, held as last index
    logic [IW-1:0]                       last_col_reg;
    logic [fdg_pkg::ROW_BITS-1:0]        last_row_reg;
    logic [fdg_pkg::AXIS_BITS-1:0]       axis_reg;

    // frame position
    logic [IW-1:0]                       col_reg, col_next;
    logic [fdg_pkg::ROW_BITS-1:0]        row_reg, row_next;
    logic                                drain_reg, drain_next;

    // line buffers
    logic signed [SAMPLE_BITS-1:0]       curr_line_mem [MAX_COLS];
    logic signed [SAMPLE_BITS-1:0]       prev_line_mem [MAX_COLS];

    // window around the output element
    logic signed [SAMPLE_BITS-1:0]       cur_reg;    // output row, this column
    logic signed [SAMPLE_BITS-1:0]       right_reg;  // output row, next column
    logic signed [SAMPLE_BITS-1:0]       left_reg;   // output row, previous column
    logic signed [SAMPLE_BITS-1:0]       above_reg;  // row before the output row

    logic                                accept;
    logic                                restart;
    logic                                at_last_col;
    logic                                at_last_row;
    logic                                single_col;
    logic                                single_row;
    logic                                drain_row;
    logic                                emit;
    logic [IW-1:0]                       col_plus1;
    logic [IW-1:0]                       col_plus2;
    logic [IW:0]                         col_ext;
    logic [IW:0]                         last_ext;
    logic [IW-1:0]                       right_raddr;
    logic [IW-1:0]                       above_raddr;
    logic [CMPW-1:0]                     cols_raw;
    logic [IW-1:0]                       cols_last_new;

    assign sample_stall = q_full;
    assign accept       = sample_valid && !q_full;

    assign restart = cfg_write_en && (cfg_index == fdg_pkg::REG_FRAME_COLS ||
                                      cfg_index == fdg_pkg::REG_FRAME_ROWS ||
                                      cfg_index == fdg_pkg::REG_AXIS_SELECT);

    // clamp column count to 1..MAX_COLS
    always_comb
    begin
        cols_raw = CMPW'(cfg_data[fdg_pkg::FRAME_COLS_BITS-1:0]);
        if (cols_raw == '0)
        begin
            cols_last_new = '0;
        end
        else if (cols_raw > CMPW'(MAX_COLS))
        begin
            cols_last_new = IW'(MAX_COLS - 1);
        end
        else
        begin
            cols_last_new = IW'(cols_raw - CMPW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= IW'(RESET_COLS - 1);
            last_row_reg <= fdg_pkg::LAST_ROW_RESET;
            axis_reg     <= fdg_pkg::AXIS_HORIZONTAL;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                fdg_pkg::REG_FRAME_COLS:
                begin
                    last_col_reg <= cols_last_new;
                end
                fdg_pkg::REG_FRAME_ROWS:
                begin
                    last_row_reg <= (cfg_data == '0) ? '0 : cfg_data - 16'd1;
                end
                fdg_pkg::REG_AXIS_SELECT:
                begin
                    axis_reg <= cfg_data[fdg_pkg::AXIS_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign at_last_col = (col_reg == last_col_reg);
    assign at_last_row = (row_reg == last_row_reg);
    assign single_col  = (last_col_reg == '0);
    assign single_row  = (last_row_reg == '0);
    assign drain_row   = (row_reg == '0);
    assign emit        = !drain_row || drain_reg;

    // column + 1 and column + 2, modulo the row length (column + 2 only for rows of two or more)
    assign col_ext   = {1'b0, col_reg};
    assign last_ext  = {1'b0, last_col_reg};
    assign col_plus1 = at_last_col ? '0 : col_reg + IW'(1);
    assign col_plus2 = (col_ext + (IW+1)'(1) >= last_ext)
                     ? IW'(col_ext + (IW+1)'(1) - last_ext)
                     : IW'(col_ext + (IW+1)'(2));

    // prefetch addresses for the next item's window
    assign right_raddr = accept ? col_plus2 : col_plus1;
    assign above_raddr = accept ? col_plus1 : col_reg;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        if (restart)
        begin
            col_next   = '0;
            row_next   = '0;
            drain_next = 1'b0;
        end
        else if (accept)
        begin
            if (at_last_col)
            begin
                col_next = '0;
                if (at_last_row)
                begin
                    row_next   = '0;
                    drain_next = 1'b1;
                end
                else
                begin
                    row_next   = row_reg + 16'd1;
                    drain_next = 1'b0;
                end
            end
            else
            begin
                col_next = col_plus1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
        end
    end

    // line buffers with write-through on a same-address read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            curr_line_mem[col_reg] <= sample;
            prev_line_mem[col_reg] <= cur_reg;
        end
        right_reg <= (accept && right_raddr == col_reg) ? sample : curr_line_mem[right_raddr];
        above_reg <= (accept && above_raddr == col_reg) ? cur_reg : prev_line_mem[above_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg  <= single_col ? sample : right_reg;
            left_reg <= cur_reg;
        end
    end

    // operand selection
    always_comb
    begin
        q_ctrl.frame_end = drain_row && at_last_col;

        q_ctrl.v_mode = fdg_pkg::DIFF_CENTRAL;
        v_hi          = sample;
        v_lo          = above_reg;
        if (single_row || axis_reg == fdg_pkg::AXIS_HORIZONTAL)
        begin
            q_ctrl.v_mode = fdg_pkg::DIFF_ZERO;
        end
        else if (drain_row)
        begin
            q_ctrl.v_mode = fdg_pkg::DIFF_ONE_SIDED;
            v_hi          = cur_reg;
            v_lo          = above_reg;
        end
        else if (row_reg == 16'd1)
        begin
            q_ctrl.v_mode = fdg_pkg::DIFF_ONE_SIDED;
            v_hi          = sample;
            v_lo          = cur_reg;
        end

        q_ctrl.h_mode = fdg_pkg::DIFF_CENTRAL;
        h_hi          = right_reg;
        h_lo          = left_reg;
        if (single_col || axis_reg == fdg_pkg::AXIS_VERTICAL)
        begin
            q_ctrl.h_mode = fdg_pkg::DIFF_ZERO;
        end
        else if (col_reg == '0)
        begin
            q_ctrl.h_mode = fdg_pkg::DIFF_ONE_SIDED;
            h_hi          = right_reg;
            h_lo          = cur_reg;
        end
        else if (at_last_col)
        begin
            q_ctrl.h_mode = fdg_pkg::DIFF_ONE_SIDED;
            h_hi          = cur_reg;
            h_lo          = left_reg;
        end
    end

    assign q_push = accept && emit;

endmodule

### rtl/fdg_queue.sv
// ----------------------------------------------------------------------------
// fdg_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module fdg_queue #(
    parameter int DATA_BITS = 72
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 full,
    input  logic                 pop,
    output logic [DATA_BITS-1:0] pop_data,
    output logic                 not_empty
);

    localparam int PW = (fdg_pkg::QUEUE_DEPTH > 1) ? $clog2(fdg_pkg::QUEUE_DEPTH) : 1;

    logic [DATA_BITS-1:0] slot_reg [fdg_pkg::QUEUE_DEPTH];
    logic [PW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [PW:0]          count_reg, count_next;

    assign full      = (count_reg == (PW+1)'(fdg_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/fdg_back.sv
// ----------------------------------------------------------------------------
// fdg_back
// Forms both differences, scales and saturates them, and holds the result.
// ----------------------------------------------------------------------------
module fdg_back #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    output logic                                  q_pop,
    input  fdg_pkg::fdg_ctrl_t                    q_ctrl,
    input  logic signed [SAMPLE_BITS-1:0]         v_hi,
    input  logic signed [SAMPLE_BITS-1:0]         v_lo,
    input  logic signed [SAMPLE_BITS-1:0]         h_hi,
    input  logic signed [SAMPLE_BITS-1:0]         h_lo,
    output logic                                  grad_valid,
    input  logic                                  grad_stall,
    output logic signed [fdg_pkg::OUT_BITS-1:0]   grad_vertical,
    output logic signed [fdg_pkg::OUT_BITS-1:0]   grad_horizontal,
    output logic                                  frame_end
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int CW = (SAMPLE_BITS + 2 > fdg_pkg::OUT_BITS) ? SAMPLE_BITS + 2
                                                              : fdg_pkg::OUT_BITS;

    logic                                out_valid_reg;
    logic signed [fdg_pkg::OUT_BITS-1:0] gv_reg;
    logic signed [fdg_pkg::OUT_BITS-1:0] gh_reg;
    logic                                fe_reg;

    function automatic logic signed [fdg_pkg::OUT_BITS-1:0] scale_sat(
        input logic signed [SAMPLE_BITS-1:0] hi,
        input logic signed [SAMPLE_BITS-1:0] lo,
        input fdg_pkg::diff_mode_t           mode
    );
        logic signed [DW-1:0] d;
        logic signed [CW-1:0] s;
        logic signed [fdg_pkg::OUT_BITS-1:0] r;
        d = DW'(hi) - DW'(lo);
        case (mode)
            fdg_pkg::DIFF_CENTRAL:   s = CW'(d);
            fdg_pkg::DIFF_ONE_SIDED: s = CW'(d) <<< 1;
            default:                 s = '0;
        endcase
        if (s > CW'(fdg_pkg::OUT_MAX))
        begin
            r = fdg_pkg::OUT_MAX;
        end
        else if (s < CW'(fdg_pkg::OUT_MIN))
        begin
            r = fdg_pkg::OUT_MIN;
        end
        else
        begin
            r = fdg_pkg::OUT_BITS'(s);
        end
        return r;
    endfunction

    assign q_pop = q_valid && (!out_valid_reg || !grad_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!grad_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            gv_reg <= scale_sat(v_hi, v_lo, q_ctrl.v_mode);
            gh_reg <= scale_sat(h_hi, h_lo, q_ctrl.h_mode);
            fe_reg <= q_ctrl.frame_end;
        end
    end

    assign grad_valid      = out_valid_reg;
    assign grad_vertical   = gv_reg;
    assign grad_horizontal = gh_reg;
    assign frame_end       = fe_reg;

endmodule

### rtl/finite_difference_gradient_2d.sv
// ----------------------------------------------------------------------------
// finite_difference_gradient_2d
// Central-difference gradient of a row-major sample stream, one or both axes.
// ----------------------------------------------------------------------------
// Takes one signed sample per clock, row-major, and returns each element's
// gradient along rows (grad_vertical) and columns (grad_horizontal) with one
// fractional bit: interior points get (next - previous), the first and last
// point of an axis get twice the one-sided difference, an axis of length one
// gives zero. A result comes out one row after its element: the element at
// (r, c) is released by the transfer of the sample one row later, so the first
// row after reset or a configuration write gives no results and a frame's last
// row comes out while the next frame's first row goes in. Throughput is one
// sample per clock, sustained, as long as the result side keeps up; the result
// passes through the queue into the output register after the transfer that
// releases it. The rate is set by the two line buffers (MAX_COLS entries each,
// one write and one prefetch read per clock). Output stall backs up through a
// two-entry queue before the input stalls. Line buffers have no clearing pass;
// every entry is written before it is read. Write configuration only while the
// block is idle; any write to a defined register restarts the frame at row 0,
// column 0 and drops a last row still waiting for output.
// ----------------------------------------------------------------------------
module finite_difference_gradient_2d #(
    parameter int MAX_COLS    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_write_en,
    input  logic [fdg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [fdg_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // sample channel
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    // result channel
    output logic                                  grad_valid,
    input  logic                                  grad_stall,
    output logic signed [fdg_pkg::OUT_BITS-1:0]   grad_vertical,
    output logic signed [fdg_pkg::OUT_BITS-1:0]   grad_horizontal,
    output logic                                  frame_end
);

    localparam int CTRL_BITS  = $bits(fdg_pkg::fdg_ctrl_t);
    localparam int ENTRY_BITS = CTRL_BITS + 4 * SAMPLE_BITS;

    // front -> queue
    logic                           push;
    logic                           q_full;
    fdg_pkg::fdg_ctrl_t             push_ctrl;
    logic signed [SAMPLE_BITS-1:0]  push_v_hi, push_v_lo, push_h_hi, push_h_lo;
    logic [ENTRY_BITS-1:0]          push_data;

    // queue -> back
    logic                           q_not_empty;
    logic                           pop;
    logic [ENTRY_BITS-1:0]          pop_data;
    fdg_pkg::fdg_ctrl_t             pop_ctrl;
    logic signed [SAMPLE_BITS-1:0]  pop_v_hi, pop_v_lo, pop_h_hi, pop_h_lo;

    // Front: position tracking, line buffers, operand and case selection.
    fdg_front #(
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample       (sample),
        .sample_stall (sample_stall),
        .q_full       (q_full),
        .q_push       (push),
        .q_ctrl       (push_ctrl),
        .v_hi         (push_v_hi),
        .v_lo         (push_v_lo),
        .h_hi         (push_h_hi),
        .h_lo         (push_h_lo)
    );

    assign push_data = {push_ctrl, push_v_hi, push_v_lo, push_h_hi, push_h_lo};

    // Queue decouples the sample side from the result side.
    fdg_queue #(
        .DATA_BITS (ENTRY_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (q_not_empty)
    );

    assign pop_ctrl = fdg_pkg::fdg_ctrl_t'(pop_data[ENTRY_BITS-1 -: CTRL_BITS]);
    assign pop_v_hi = pop_data[4*SAMPLE_BITS-1 -: SAMPLE_BITS];
    assign pop_v_lo = pop_data[3*SAMPLE_BITS-1 -: SAMPLE_BITS];
    assign pop_h_hi = pop_data[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
    assign pop_h_lo = pop_data[SAMPLE_BITS-1:0];

    // Back: subtract, scale, saturate, output register.
    fdg_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_not_empty),
        .q_pop           (pop),
        .q_ctrl          (pop_ctrl),
        .v_hi            (pop_v_hi),
        .v_lo            (pop_v_lo),
        .h_hi            (pop_h_hi),
        .h_lo            (pop_h_lo),
        .grad_valid      (grad_valid),
        .grad_stall      (grad_stall),
        .grad_vertical   (grad_vertical),
        .grad_horizontal (grad_horizontal),
        .frame_end       (frame_end)
    );

endmodule

### rtl/fdg_checker.sv
// ----------------------------------------------------------------------------
// fdg_checker
// Port-level checks for the gradient block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdg_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [fdg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [fdg_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  sample_valid,
    input  logic                                  sample_stall,
    input  logic                                  grad_valid,
    input  logic                                  grad_stall,
    input  logic signed [fdg_pkg::OUT_BITS-1:0]   grad_vertical,
    input  logic signed [fdg_pkg::OUT_BITS-1:0]   grad_horizontal,
    input  logic                                  frame_end
);

    // a result needs a sample transfer one row later, so at least two
    localparam logic [1:0] MIN_XFERS = 2'd2;

    logic [fdg_pkg::AXIS_BITS-1:0] axis_reg;
    logic [1:0]                    xfer_cnt_reg;
    logic                          restart;

    assign restart = cfg_write_en && (cfg_index == fdg_pkg::REG_FRAME_COLS ||
                                      cfg_index == fdg_pkg::REG_FRAME_ROWS ||
                                      cfg_index == fdg_pkg::REG_AXIS_SELECT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg     <= fdg_pkg::AXIS_HORIZONTAL;
            xfer_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_write_en && cfg_index == fdg_pkg::REG_AXIS_SELECT)
            begin
                axis_reg <= cfg_data[fdg_pkg::AXIS_BITS-1:0];
            end
            if (restart)
            begin
                xfer_cnt_reg <= '0;
            end
            else if (sample_valid && !sample_stall && xfer_cnt_reg != MIN_XFERS)
            begin
                xfer_cnt_reg <= xfer_cnt_reg + 2'd1;
            end
        end
    end

    `ASSERT_NEXT(a_result_holds, clk, rst_n, grad_valid && grad_stall, grad_valid && $stable(grad_vertical) && $stable(grad_horizontal) && $stable(frame_end), "stalled result changed or dropped")
    `ASSERT_IMPLY(a_vertical_only, clk, rst_n, grad_valid && axis_reg == fdg_pkg::AXIS_VERTICAL, grad_horizontal == '0, "horizontal gradient nonzero with vertical axis only")
    `ASSERT_IMPLY(a_horizontal_only, clk, rst_n, grad_valid && axis_reg == fdg_pkg::AXIS_HORIZONTAL, grad_vertical == '0, "vertical gradient nonzero with horizontal axis only")
    `ASSERT_IMPLY(a_result_after_row, clk, rst_n, grad_valid, xfer_cnt_reg == MIN_XFERS, "result before a second sample transfer")
    `ASSERT_IMPLY(a_stall_from_output, clk, rst_n, sample_stall, grad_valid, "input stalled without a pending result")

endmodule

bind finite_difference_gradient_2d fdg_checker u_fdg_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .grad_valid      (grad_valid),
    .grad_stall      (grad_stall),
    .grad_vertical   (grad_vertical),
    .grad_horizontal (grad_horizontal),
    .frame_end       (frame_end)
);

### tb/tb_finite_difference_gradient_2d.sv
// ----------------------------------------------------------------------------
// tb_finite_difference_gradient_2d
// Self-checking bench for the streaming 2-D central-difference gradient.
// ----------------------------------------------------------------------------
// Samples go in row-major through the valid/stall channel. A cycle-free
// predictor mirrors the line buffers and frame position and queues the
// gradient each transfer releases. A checker compares every result transfer
// field by field against the oldest queued gradient. Coverage comes from the
// reset shape, directed corner frames, an oversized column count and four
// random phases with different sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_finite_difference_gradient_2d;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LEN      = 1024;   // MAX_COLS of the instance
    localparam int SETTLE_CYCLES = 8;      // quiet time before a register write
    localparam int MAX_REPORTS   = 10;
    localparam int RESET_ROW_LEN = 16;     // samples sent in the reset shape
    // no register here
    localparam logic [fdg_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [fdg_pkg::OUT_BITS-1:0] vertical;
        logic signed [fdg_pkg::OUT_BITS-1:0] horizontal;
        logic                                last;
    } gradient_t;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                                  clk          = 1'b0;
    logic                                  rst_n        = 1'b0;
    logic                                  cfg_write_en = 1'b0;
    logic [fdg_pkg::CFG_INDEX_BITS-1:0]    cfg_index    = '0;
    logic [fdg_pkg::CFG_DATA_BITS-1:0]     cfg_data     = '0;
    logic                                  sample_valid = 1'b0;
    logic                                  sample_stall;
    logic signed [15:0]                    sample       = '0;
    logic                                  grad_valid;
    logic                                  grad_stall   = 1'b0;
    logic signed [fdg_pkg::OUT_BITS-1:0]   grad_vertical;
    logic signed [fdg_pkg::OUT_BITS-1:0]   grad_horizontal;
    logic                                  frame_end;

    finite_difference_gradient_2d dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .grad_valid      (grad_valid),
        .grad_stall      (grad_stall),
        .grad_vertical   (grad_vertical),
        .grad_horizontal (grad_horizontal),
        .frame_end       (frame_end)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: register copies, two line buffers, frame position
    // ------------------------------------------------------------------------
    logic [fdg_pkg::FRAME_COLS_BITS-1:0] cols_reg = 11'(fdg_pkg::COLS_RESET);
    logic [fdg_pkg::FRAME_ROWS_BITS-1:0] rows_reg = 16'd1;
    logic [fdg_pkg::AXIS_BITS-1:0]       axis_reg = fdg_pkg::AXIS_HORIZONTAL;

    int  prev_line [LINE_LEN];
    int  curr_line [LINE_LEN];
    int  row_pos       = 0;
    int  col_pos       = 0;
    bit  drain_pending = 1'b0;

    gradient_t results_due [$];   // gradients released but not yet seen
    int        fail_count    = 0;
    int        send_idle_pct = 0; // chance per cycle that the sender holds off
    int        stall_pct     = 0; // chance per cycle that the receiver stalls

    // Out-of-range register values fold onto the legal shape.
    function automatic int frame_width();
        if (cols_reg == 0)
            return 1;
        if (cols_reg > LINE_LEN)
            return LINE_LEN;
        return int'(cols_reg);
    endfunction

    function automatic int frame_height();
        return (rows_reg == 0) ? 1 : int'(rows_reg);
    endfunction

    // One accepted sample: queue the result it releases (the element one row
    // back), then shift it into the line buffers and advance the position.
    task automatic predict_gradient(input logic signed [15:0] value);
        int        ncols;
        int        nrows;
        int        c;
        int        x;
        int        cur;
        int        gv;
        int        gh;
        bit        last_row;
        gradient_t res;
        ncols = frame_width();
        nrows = frame_height();
        c     = col_pos;
        x     = int'(value);
        if (c >= ncols)
            c = 0;

        if (row_pos >= 1 || drain_pending)
        begin
            last_row = (row_pos == 0);
            cur      = curr_line[c];

            if (nrows == 1)
                gv = 0;
            else if (last_row)
                gv = 2 * (cur - prev_line[c]);
            else if (row_pos == 1)
                gv = 2 * (x - cur);
            else
                gv = x - prev_line[c];

            // left neighbor of the output row has already moved to prev_line
            if (ncols == 1)
                gh = 0;
            else if (c == 0)
                gh = 2 * (curr_line[1] - cur);
            else if (c == ncols - 1)
                gh = 2 * (cur - prev_line[c - 1]);
            else
                gh = curr_line[c + 1] - prev_line[c - 1];

            if (axis_reg == fdg_pkg::AXIS_VERTICAL)
                gh = 0;
            else if (axis_reg == fdg_pkg::AXIS_HORIZONTAL)
                gv = 0;

            res.vertical   = gv[fdg_pkg::OUT_BITS-1:0];
            res.horizontal = gh[fdg_pkg::OUT_BITS-1:0];
            res.last       = last_row && (c == ncols - 1);
            results_due.push_back(res);
        end

        prev_line[c] = curr_line[c];
        curr_line[c] = x;

        c++;
        if (c >= ncols)
        begin
            c = 0;
            if (row_pos + 1 >= nrows)
            begin
                row_pos       = 0;
                drain_pending = 1'b1;
            end
            else
            begin
                row_pos++;
                drain_pending = 1'b0;
            end
        end
        col_pos = c;
    endtask

    // ------------------------------------------------------------------------
    // Result checker: one expectation per result transfer, oldest first
    // ------------------------------------------------------------------------
    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : check_results
        gradient_t want;
        if (rst_n && grad_valid && !grad_stall)
        begin
            if (results_due.size() == 0)
                note_failure($sformatf("unexpected result v=%0d h=%0d end=%0b",
                                       grad_vertical, grad_horizontal, frame_end));
            else
            begin
                want = results_due.pop_front();
                if (grad_vertical !== want.vertical)
                    note_failure($sformatf("grad_vertical exp %0d got %0d",
                                           want.vertical, grad_vertical));
                if (grad_horizontal !== want.horizontal)
                    note_failure($sformatf("grad_horizontal exp %0d got %0d",
                                           want.horizontal, grad_horizontal));
                if (frame_end !== want.last)
                    note_failure($sformatf("frame_end exp %0b got %0b",
                                           want.last, frame_end));
            end
        end
    end

    // Receiver side: random stall, changed on the falling edge only.
    always @(negedge clk)
        grad_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Called on a falling edge; returns on the falling edge after the transfer.
    // Valid stays high on return so back-to-back samples need no gap.
    task automatic send_sample(input logic signed [15:0] value);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            sample_valid = 1'b0;
            sample       = 16'($urandom);
            @(negedge clk);
        end
        sample_valid = 1'b1;
        sample       = value;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        predict_gradient(value);
        @(negedge clk);
    endtask

    // Hold the sender off until every released result has been seen.
    task automatic pause_until_drained();
        sample_valid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Register writes only while idle. A write to a real register restarts
    // the frame and drops any last row still waiting for output.
    task automatic write_register(input logic [fdg_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [fdg_pkg::CFG_DATA_BITS-1:0] data);
        bit known;
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = data;
        @(negedge clk);
        cfg_write_en = 1'b0;

        known = 1'b1;
        case (idx)
            fdg_pkg::REG_FRAME_COLS:  cols_reg = data[fdg_pkg::FRAME_COLS_BITS-1:0];
            fdg_pkg::REG_FRAME_ROWS:  rows_reg = data[fdg_pkg::FRAME_ROWS_BITS-1:0];
            fdg_pkg::REG_AXIS_SELECT: axis_reg = data[fdg_pkg::AXIS_BITS-1:0];
            default:                  known = 1'b0;
        endcase
        if (known)
        begin
            row_pos       = 0;
            col_pos       = 0;
            drain_pending = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset shape: 1024 columns, one row per frame, horizontal only. A short
    // run inside the first row, which must release nothing; the register
    // write of the next test cuts the row off.
    task automatic test_reset_shape();
        send_idle_pct = 0;
        stall_pct     = 0;
        for (int i = 0; i < RESET_ROW_LEN; i++)
            send_sample(16'($urandom));
    endtask

    // 3x3 frame of mostly full-scale samples with the spare axis code (acts as both):
    // corner, edge and interior cases on both axes, largest magnitudes.
    task automatic test_extreme_grid();
        logic signed [15:0] grid [9];
        grid = '{16'sh7FFF, 16'sh8000, 16'sh7FFF,
                 16'sh8000, 16'sh0000, 16'sh7FFF,
                 16'sh7FFF, 16'shFFFF, 16'sh8000};
        send_idle_pct = 30;
        stall_pct     = 30;
        write_register(fdg_pkg::REG_FRAME_COLS, 16'd3);
        write_register(fdg_pkg::REG_FRAME_ROWS, 16'd3);
        write_register(fdg_pkg::REG_AXIS_SELECT, 16'hFFFF);
        foreach (grid[i])
            send_sample(grid[i]);
        // let the first two rows drain before the next frame flushes the last
        pause_until_drained();
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        send_sample(16'sh0000);
    endtask

    // Each single-axis mode on a 2x2 frame: the other output must read zero.
    task automatic test_axis_modes();
        send_idle_pct = 20;
        stall_pct     = 20;
        write_register(fdg_pkg::REG_FRAME_COLS, 16'd2);
        write_register(fdg_pkg::REG_FRAME_ROWS, 16'd2);
        write_register(fdg_pkg::REG_AXIS_SELECT, 16'(fdg_pkg::AXIS_VERTICAL));
        repeat (6) send_sample(16'($urandom));
        write_register(fdg_pkg::REG_AXIS_SELECT, 16'(fdg_pkg::AXIS_HORIZONTAL));
        repeat (6) send_sample(16'($urandom));
    endtask

    // Zero column and row counts act as one (every sample is a frame, all
    // gradients zero). A write to the unused index must not restart the frame,
    // so the pending last row still drains afterwards.
    task automatic test_degenerate_shapes();
        send_idle_pct = 20;
        stall_pct     = 20;
        write_register(fdg_pkg::REG_FRAME_COLS, 16'hF800);
        write_register(fdg_pkg::REG_FRAME_ROWS, 16'd0);
        repeat (4) send_sample(16'($urandom));
        write_register(REG_SPARE, 16'hFFFF);
        send_sample(16'($urandom));
    endtask

    // Column count above the line length folds to the full line; also the
    // largest row count, so the frame never ends inside this test.
    task automatic test_oversize_columns();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_register(fdg_pkg::REG_FRAME_COLS, 16'hFFFF);
        write_register(fdg_pkg::REG_FRAME_ROWS, 16'hFFFF);
        write_register(fdg_pkg::REG_AXIS_SELECT, 16'(fdg_pkg::AXIS_BOTH));
        repeat (LINE_LEN + 8) send_sample(16'($urandom));
    endtask

    // Random frame shapes and contents. Mostly whole frames plus one flush
    // row; some truncated streams that the next register write cuts off.
    task automatic test_random_frames(input int idle_pct, input int hold_pct,
                                      input int budget);
        int                 sent;
        int                 count;
        int                 pick;
        int                 ncols;
        logic [15:0]        data;
        logic signed [15:0] value;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        sent          = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(1, 7);
            if (pick[0])
            begin
                case ($urandom_range(9))
                    0:       ncols = 1;
                    1:       ncols = 2;
                    7:       ncols = $urandom_range(11, 40);
                    8:       ncols = 0;
                    default: ncols = $urandom_range(3, 10);
                endcase
                data = 16'($urandom);
                data[fdg_pkg::FRAME_COLS_BITS-1:0] = 11'(ncols);
                write_register(fdg_pkg::REG_FRAME_COLS, data);
            end
            if (pick[1])
            begin
                case ($urandom_range(11))
                    0:       data = 16'd0;
                    1:       data = 16'hFFFF;
                    2:       data = 16'($urandom);
                    default: data = 16'($urandom_range(1, 5));
                endcase
                write_register(fdg_pkg::REG_FRAME_ROWS, data);
            end
            if (pick[2])
                write_register(fdg_pkg::REG_AXIS_SELECT, 16'($urandom));

            if ($urandom_range(7) == 0 || frame_width() * frame_height() > 240)
                count = $urandom_range(1, 60);
            else
                count = frame_width() * frame_height() * $urandom_range(1, 3)
                        + frame_width();

            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(7) == 0)
                    value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                else
                    value = 16'($urandom);
                send_sample(value);
                if ($urandom_range(127) == 0)
                    pause_until_drained();
            end
            sent += count;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        foreach (prev_line[i])
        begin
            prev_line[i] = 0;
            curr_line[i] = 0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_shape();
        test_extreme_grid();
        test_axis_modes();
        test_degenerate_shapes();
        test_oversize_columns();
        test_random_frames(0, 0, 130);      // full rate
        test_random_frames(87, 0, 130);     // sparse sender
        test_random_frames(0, 87, 130);     // back-pressured receiver
        test_random_frames(11, 11, 130);    // light gaps on both sides

        // final drain, then a quiet window to catch stray results
        sample_valid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/fdg_pkg.sv
rtl/fdg_front.sv
rtl/fdg_queue.sv
rtl/fdg_back.sv
rtl/finite_difference_gradient_2d.sv
rtl/fdg_checker.sv
tb/tb_finite_difference_gradient_2d.sv
